// ----- rtl/core/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded value set package
// Sizes, operation codes and sequencer states used by the set unit; its
// checker uses the output count width.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int SET_DEPTH   = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W   = $clog2(SET_DEPTH + 1);
  localparam int OP_W    = 2;
  localparam int IN_VAL_W = 32;
  localparam int CAP_W   = 5;
  localparam int OUT_CNT_W = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_LAST,
    ST_MOVE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/bounded_value_set_unit.sv -----
// ----------------------------------------------------------------------------
// Bounded value set unit
// An accepted word is compared against the stored words in turn, stopping at
// a match, and then acted on; a remove that finds its value moves the last
// stored word into the freed slot. The result is then registered to the
// output; a stalled result holds the unit until it can be loaded. A new word
// is taken only once the previous result has been loaded.
// Reset is synchronous and active low: the set empties, the capacity limit
// returns to 16 and no result is pending.
// ----------------------------------------------------------------------------
module bounded_value_set_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bvs_pkg::OP_W-1:0]       in_op,
  input  logic [bvs_pkg::IN_VAL_W-1:0]   in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_success,
  output logic [bvs_pkg::OUT_CNT_W-1:0]  out_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bvs_pkg::CAP_W-1:0]      cfg_data
);
  import bvs_pkg::*;

  state_t state_r, state_nxt;

  value_t mem [SET_DEPTH];
  value_t rd_data_r;
  idx_t   rd_addr;
  logic   mem_we;
  idx_t   mem_waddr;
  value_t mem_wdata;

  op_t    op_r, op_nxt;
  value_t val_r, val_nxt;
  idx_t   idx_r, idx_nxt;
  idx_t   slot_r, slot_nxt;
  logic   found_r, found_nxt;
  logic   succ_r, succ_nxt;
  cnt_t   count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;

  logic   out_valid_r, out_valid_nxt;
  logic   out_success_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic   in_take;
  logic   out_load;
  logic   hit;
  logic   scan_end;
  logic   room;
  logic [CMP_W-1:0] eff_cap;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign eff_cap  = (CMP_W'(cap_r) > CMP_W'(SET_DEPTH)) ? CMP_W'(SET_DEPTH) : CMP_W'(cap_r);
  assign room     = CMP_W'(count_r) < eff_cap;
  assign hit      = (rd_data_r == val_r);
  assign scan_end = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (op_t'(in_op) == OP_NONE || count_r == '0) begin
            state_nxt = ST_ACT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (op_r == OP_REMOVE && found_r) begin
          state_nxt = ST_LAST;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LAST: state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    found_nxt = found_r;
    succ_nxt  = succ_r;
    count_nxt = count_r;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = rd_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          op_nxt    = op_t'(in_op);
          val_nxt   = VALUE_WIDTH'(in_value);
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        rd_addr = idx_r + idx_t'(1);
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
        end else begin
          idx_nxt = idx_r + idx_t'(1);
        end
      end
      ST_ACT: begin
        rd_addr  = idx_t'(count_r - CNT_W'(1));
        succ_nxt = 1'b0;
        case (op_r)
          OP_ADD: begin
            if (!found_r && room) begin
              mem_we    = 1'b1;
              mem_waddr = idx_t'(count_r);
              mem_wdata = val_r;
              count_nxt = count_r + CNT_W'(1);
              succ_nxt  = 1'b1;
            end
          end
          OP_LOOKUP: succ_nxt = found_r;
          default:   succ_nxt = 1'b0;
        endcase
      end
      ST_LAST: begin
        rd_addr = idx_t'(count_r - CNT_W'(1));
      end
      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = rd_data_r;
        count_nxt = count_r - CNT_W'(1);
        succ_nxt  = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    found_r <= found_nxt;
    succ_r  <= succ_nxt;
    if (out_load) begin
      out_success_r <= succ_r;
      out_count_r   <= OUT_CNT_W'(count_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;
  assign out_count   = out_count_r;

endmodule

// ----- rtl/core/bvs_checker.sv -----
// ----------------------------------------------------------------------------
// Bounded value set checker
// Port-level checks on the set unit, attached to every instance of it by bind.
// ----------------------------------------------------------------------------
module bvs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_success,
  input logic [bvs_pkg::OUT_CNT_W-1:0]  out_count,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // An accepted word keeps the unit busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit accepted a word but was not busy afterwards");

  // A held result does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_success) && $stable(out_count))
    else $error("stalled result changed");

  // A new result only appears at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // The configuration port is only open while no word is in progress.
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !in_stall)
    else $error("configuration write taken while busy");

endmodule

bind bounded_value_set_unit bvs_checker u_bvs_checker (.*);
